// File: design/grouped_pair_interval_bounding_box_assert.svh
// Assertion macros used by the checker file of the pair bounding box block.
`ifndef GROUPED_PAIR_INTERVAL_BOUNDING_BOX_ASSERT_SVH
`define GROUPED_PAIR_INTERVAL_BOUNDING_BOX_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define GPIBB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpibb assertion failed");

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define GPIBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpibb assertion failed");

`endif

// File: design/gpibb_pkg.sv
// Types and constants of the pair bounding box block.
`default_nettype none

package gpibb_pkg;

    localparam int COORD_BITS    = 31;
    localparam int CHROM_BITS    = 16;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register select: the word index bit of paddr.
    localparam logic REG_REFLECT_ENABLE = 1'b0;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [CHROM_BITS-1:0] t_chrom;

    typedef struct packed {
        t_chrom chrom_first;
        t_coord start_first;
        t_coord end_first;
        t_chrom chrom_second;
        t_coord start_second;
        t_coord end_second;
        logic   group_last;
    } t_pair;

    typedef struct packed {
        t_chrom box_chrom_left;
        t_coord box_start_left;
        t_coord box_end_left;
        t_chrom box_chrom_right;
        t_coord box_start_right;
        t_coord box_end_right;
        logic   mixed_chromosomes;
    } t_box;

    // Lexicographic (chromosome, start, end) order of two anchors.
    function automatic logic anchor_greater(input t_chrom ca, input t_coord sa,
                                            input t_coord ea, input t_chrom cb,
                                            input t_coord sb, input t_coord eb);
        return {ca, sa, ea} > {cb, sb, eb};
    endfunction

endpackage

`default_nettype wire

// File: design/gpibb_pair_if.sv
// Input channel: one interval pair per word.
`default_nettype none

interface gpibb_pair_if import gpibb_pkg::*; ();
    logic  valid;
    logic  ready;
    t_pair data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/gpibb_box_if.sv
// Output channel: one group bounding box per word.
`default_nettype none

interface gpibb_box_if import gpibb_pkg::*; ();
    logic valid;
    logic ready;
    t_box data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/grouped_pair_interval_bounding_box.sv
// A box enters the box register when its group's last pair leaves the input register.
// Throughput: one pair per cycle; the input stalls only when a last pair finds the
// box register still full and not being drained in that cycle.
// With reflect_enable set, pairs are put in canonical order as they enter the input register.
// Reset (synchronous, active low) clears reflect_enable, the open-group flag and the
// valid flags; accumulators and the box register hold no reset value.
`default_nettype none

module grouped_pair_interval_bounding_box import gpibb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    gpibb_pair_if.sink               i_pair,
    gpibb_box_if.source              o_box
);

    logic  r_reflect;
    logic  r_in_valid;
    t_pair r_in;
    t_pair n_in;
    logic  r_group_open;
    t_box  r_acc;
    t_box  n_acc;
    logic  r_out_valid;
    t_box  r_out;

    logic  w_cfg_wr;
    logic  w_swap;
    logic  w_in_accept;
    logic  w_proceed;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reflect <= 1'b0;
        end else if (w_cfg_wr && (paddr[APB_ADDR_BITS-1] == REG_REFLECT_ENABLE)) begin
            r_reflect <= pwdata[0];
        end
    end

    assign prdata = (paddr[APB_ADDR_BITS-1] == REG_REFLECT_ENABLE)
                  ? {{(APB_DATA_BITS-1){1'b0}}, r_reflect} : '0;

    // Canonical order at the input register
    assign w_swap = r_reflect && anchor_greater(
        i_pair.data.chrom_first,  i_pair.data.start_first,  i_pair.data.end_first,
        i_pair.data.chrom_second, i_pair.data.start_second, i_pair.data.end_second);

    always_comb begin
        n_in = i_pair.data;
        if (w_swap) begin
            n_in.chrom_first  = i_pair.data.chrom_second;
            n_in.start_first  = i_pair.data.start_second;
            n_in.end_first    = i_pair.data.end_second;
            n_in.chrom_second = i_pair.data.chrom_first;
            n_in.start_second = i_pair.data.start_first;
            n_in.end_second   = i_pair.data.end_first;
        end
    end

    // A non-last word never needs the box register, so only a last word can stall.
    assign w_proceed   = r_in_valid && (!r_in.group_last || !r_out_valid || o_box.ready);
    assign i_pair.ready = i_rst_n && (!r_in_valid || w_proceed);
    assign w_in_accept = i_pair.valid && i_pair.ready;

    // Merge the held pair into the group box
    always_comb begin
        if (!r_group_open) begin
            n_acc.box_chrom_left    = r_in.chrom_first;
            n_acc.box_start_left    = r_in.start_first;
            n_acc.box_end_left      = r_in.end_first;
            n_acc.box_chrom_right   = r_in.chrom_second;
            n_acc.box_start_right   = r_in.start_second;
            n_acc.box_end_right     = r_in.end_second;
            n_acc.mixed_chromosomes = 1'b0;
        end else begin
            n_acc = r_acc;
            if ((r_in.chrom_first != r_acc.box_chrom_left)
                || (r_in.chrom_second != r_acc.box_chrom_right)) begin
                n_acc.mixed_chromosomes = 1'b1;
            end
            if (r_in.start_first < r_acc.box_start_left) begin
                n_acc.box_start_left = r_in.start_first;
            end
            if (r_in.end_first > r_acc.box_end_left) begin
                n_acc.box_end_left = r_in.end_first;
            end
            if (r_in.start_second < r_acc.box_start_right) begin
                n_acc.box_start_right = r_in.start_second;
            end
            if (r_in.end_second > r_acc.box_end_right) begin
                n_acc.box_end_right = r_in.end_second;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_group_open <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_proceed) begin
                r_in_valid <= 1'b0;
            end
            if (w_proceed) begin
                r_group_open <= !r_in.group_last;
            end
            if (w_proceed && r_in.group_last) begin
                r_out_valid <= 1'b1;
            end else if (o_box.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= n_in;
        end
        if (w_proceed) begin
            r_acc <= n_acc;
            if (r_in.group_last) begin
                r_out <= n_acc;
            end
        end
    end

    assign o_box.valid = r_out_valid;
    assign o_box.data  = r_out;

endmodule

`default_nettype wire

// File: design/gpibb_checker.sv
// Port checker for the pair bounding box block and its bind.
`default_nettype none

`include "grouped_pair_interval_bounding_box_assert.svh"

module gpibb_checker import gpibb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_box i_out_data
);

    // A stalled box word holds.
    `GPIBB_ASSERT_NEXT(a_box_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_data))

    // A fresh box word must follow an accepted last pair.
    `GPIBB_ASSERT_NOW(a_box_source, i_clk, i_rst_n, $rose(i_out_valid),
        $past(i_in_valid && i_in_ready && i_in_last, 2))

    // With the box register empty the input never stalls.
    `GPIBB_ASSERT_NOW(a_no_stall, i_clk, i_rst_n, !i_out_valid, i_in_ready)

endmodule

bind grouped_pair_interval_bounding_box gpibb_checker u_gpibb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pair.valid),
    .i_in_ready  (i_pair.ready),
    .i_in_last   (i_pair.data.group_last),
    .i_out_valid (o_box.valid),
    .i_out_ready (o_box.ready),
    .i_out_data  (o_box.data)
);

`default_nettype wire
